// ===== rtl/core/gsha_pkg.sv =====
// ----------------------------------------------------------------------------
// gsha_pkg
// Shared types, codes and constants of the generational slot handle allocator.
// ----------------------------------------------------------------------------
package gsha_pkg;

	localparam int unsigned DIR_SLOTS_DEF   = 4;
	localparam int unsigned POINT_SLOTS_DEF = 32;
	localparam int unsigned SPOT_SLOTS_DEF  = 32;

	localparam int unsigned OP_W   = 2;
	localparam int unsigned POOL_W = 2;
	localparam int unsigned IDX_W  = 5;
	localparam int unsigned GEN_W  = 32;
	localparam int unsigned ST_W   = 2;
	localparam int unsigned CNT_W  = 6;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CHECK  = 2'd2,
		OP_CLEAR  = 2'd3
	} opcode_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	localparam logic [POOL_W-1:0] POOL_DIR   = 2'd0;
	localparam logic [POOL_W-1:0] POOL_POINT = 2'd1;
	localparam logic [POOL_W-1:0] POOL_SPOT  = 2'd2;

	typedef enum logic {
		S_IDLE   = 1'b0,
		S_LOOKUP = 1'b1
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic execute;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_blocked;
	} stat_t;

	function automatic int unsigned addr_w(input int unsigned depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

// ===== rtl/core/generational_slot_handle_allocator.sv =====
// Accept captures the input word and issues the generation RAM read; the match,
// free-slot encode and commit follow in the lookup state, which registers the
// result word. No new word is accepted until the previous one has committed.
// A waiting result does not block the next accept; commit holds only while
// the result register is still full and out_ready is low.
// Reset clears all active bits and counts and sets the generation counter to 1.
// ----------------------------------------------------------------------------
// generational_slot_handle_allocator
// Add, remove, check and clear of generational handles over three slot pools.
// ----------------------------------------------------------------------------
module generational_slot_handle_allocator #(
	parameter int unsigned DIR_SLOTS   = gsha_pkg::DIR_SLOTS_DEF,
	parameter int unsigned POINT_SLOTS = gsha_pkg::POINT_SLOTS_DEF,
	parameter int unsigned SPOT_SLOTS  = gsha_pkg::SPOT_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gsha_pkg::OP_W-1:0]     opcode,
	input  logic [gsha_pkg::POOL_W-1:0]   pool,
	input  logic [gsha_pkg::IDX_W-1:0]    handle_index,
	input  logic [gsha_pkg::GEN_W-1:0]    handle_generation,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gsha_pkg::ST_W-1:0]     status,
	output logic [gsha_pkg::IDX_W-1:0]    out_index,
	output logic [gsha_pkg::GEN_W-1:0]    out_generation,
	output logic [gsha_pkg::POOL_W-1:0]   out_pool,
	output logic [gsha_pkg::CNT_W-1:0]    pool_count
);

	gsha_pkg::cmd_t  cmd;
	gsha_pkg::stat_t stat;

	gsha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gsha_dp #(
		.DIR_SLOTS   (DIR_SLOTS),
		.POINT_SLOTS (POINT_SLOTS),
		.SPOT_SLOTS  (SPOT_SLOTS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.opcode            (opcode),
		.pool              (pool),
		.handle_index      (handle_index),
		.handle_generation (handle_generation),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.out_index         (out_index),
		.out_generation    (out_generation),
		.out_pool          (out_pool),
		.pool_count        (pool_count)
	);

endmodule

// ===== rtl/core/gsha_ram.sv =====
// ----------------------------------------------------------------------------
// gsha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gsha_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/gsha_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsha_ctrl
// Sequencer: capture a word, wait for the generation read, then commit.
// ----------------------------------------------------------------------------
module gsha_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  gsha_pkg::stat_t      stat,
	output gsha_pkg::cmd_t       cmd
);

	gsha_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gsha_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			gsha_pkg::S_IDLE: begin
				if (in_valid) begin
					state_nxt = gsha_pkg::S_LOOKUP;
				end
			end
			gsha_pkg::S_LOOKUP: begin
				if (!stat.out_blocked) begin
					state_nxt = gsha_pkg::S_IDLE;
				end
			end
			default: state_nxt = gsha_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		unique case (state_q)
			gsha_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			gsha_pkg::S_LOOKUP: begin
				// hold until the output register can take the result
				cmd.execute = !stat.out_blocked;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/core/gsha_dp.sv =====
// ----------------------------------------------------------------------------
// gsha_dp
// Datapath: slot active bits, generation RAMs, counts, counter, result register.
// ----------------------------------------------------------------------------
module gsha_dp #(
	parameter int unsigned DIR_SLOTS   = gsha_pkg::DIR_SLOTS_DEF,
	parameter int unsigned POINT_SLOTS = gsha_pkg::POINT_SLOTS_DEF,
	parameter int unsigned SPOT_SLOTS  = gsha_pkg::SPOT_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gsha_pkg::cmd_t                cmd,
	output gsha_pkg::stat_t               stat,
	input  logic [gsha_pkg::OP_W-1:0]     opcode,
	input  logic [gsha_pkg::POOL_W-1:0]   pool,
	input  logic [gsha_pkg::IDX_W-1:0]    handle_index,
	input  logic [gsha_pkg::GEN_W-1:0]    handle_generation,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gsha_pkg::ST_W-1:0]     status,
	output logic [gsha_pkg::IDX_W-1:0]    out_index,
	output logic [gsha_pkg::GEN_W-1:0]    out_generation,
	output logic [gsha_pkg::POOL_W-1:0]   out_pool,
	output logic [gsha_pkg::CNT_W-1:0]    pool_count
);

	localparam int unsigned IDX_W = gsha_pkg::IDX_W;
	localparam int unsigned GEN_W = gsha_pkg::GEN_W;
	localparam int unsigned CNT_W = gsha_pkg::CNT_W;
	localparam int unsigned DIR_AW   = gsha_pkg::addr_w(DIR_SLOTS);
	localparam int unsigned POINT_AW = gsha_pkg::addr_w(POINT_SLOTS);
	localparam int unsigned SPOT_AW  = gsha_pkg::addr_w(SPOT_SLOTS);

	// captured word
	logic [gsha_pkg::OP_W-1:0]   op_q;
	logic [gsha_pkg::POOL_W-1:0] pool_q;
	logic [IDX_W-1:0]            idx_q;
	logic [GEN_W-1:0]            gen_q;

	logic [DIR_SLOTS-1:0]   dir_act_q;
	logic [POINT_SLOTS-1:0] point_act_q;
	logic [SPOT_SLOTS-1:0]  spot_act_q;
	logic [CNT_W-1:0]       dir_cnt_q, point_cnt_q, spot_cnt_q;
	logic [GEN_W-1:0]       next_gen_q;

	logic                          out_valid_q;
	logic [gsha_pkg::ST_W-1:0]     status_q;
	logic [IDX_W-1:0]              out_index_q;
	logic [GEN_W-1:0]              out_gen_q;
	logic [gsha_pkg::POOL_W-1:0]   out_pool_q;
	logic [CNT_W-1:0]              pool_count_q;

	logic [GEN_W-1:0] dir_rdata, point_rdata, spot_rdata;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= opcode;
			pool_q <= pool;
			idx_q  <= handle_index;
			gen_q  <= handle_generation;
		end
	end

	// lowest free slot per pool
	logic             dir_free, point_free, spot_free;
	logic [IDX_W-1:0] dir_free_idx, point_free_idx, spot_free_idx;

	always_comb begin
		dir_free     = 1'b0;
		dir_free_idx = '0;
		for (int i = DIR_SLOTS - 1; i >= 0; i--) begin
			if (!dir_act_q[i]) begin
				dir_free     = 1'b1;
				dir_free_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		point_free     = 1'b0;
		point_free_idx = '0;
		for (int i = POINT_SLOTS - 1; i >= 0; i--) begin
			if (!point_act_q[i]) begin
				point_free     = 1'b1;
				point_free_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		spot_free     = 1'b0;
		spot_free_idx = '0;
		for (int i = SPOT_SLOTS - 1; i >= 0; i--) begin
			if (!spot_act_q[i]) begin
				spot_free     = 1'b1;
				spot_free_idx = IDX_W'(i);
			end
		end
	end

	// handle match per pool; an index past the pool never matches
	logic gen_nz, dir_hit, point_hit, spot_hit;

	assign gen_nz    = (gen_q != '0);
	assign dir_hit   = ({1'b0, idx_q} < (IDX_W + 1)'(DIR_SLOTS))
		&& dir_act_q[idx_q[DIR_AW-1:0]] && (dir_rdata == gen_q);
	assign point_hit = ({1'b0, idx_q} < (IDX_W + 1)'(POINT_SLOTS))
		&& point_act_q[idx_q[POINT_AW-1:0]] && (point_rdata == gen_q);
	assign spot_hit  = ({1'b0, idx_q} < (IDX_W + 1)'(SPOT_SLOTS))
		&& spot_act_q[idx_q[SPOT_AW-1:0]] && (spot_rdata == gen_q);

	// result and update decode
	logic [gsha_pkg::ST_W-1:0]   res_status;
	logic [IDX_W-1:0]            res_idx;
	logic [GEN_W-1:0]            res_gen;
	logic [gsha_pkg::POOL_W-1:0] res_pool;
	logic [CNT_W-1:0]            res_cnt;
	logic add_dir, add_point, add_spot;
	logic rm_dir, rm_point, rm_spot;
	logic clr_all;

	always_comb begin
		res_status = gsha_pkg::ST_BAD;
		res_idx    = '0;
		res_gen    = '0;
		res_pool   = '0;
		res_cnt    = '0;
		add_dir    = 1'b0;
		add_point  = 1'b0;
		add_spot   = 1'b0;
		rm_dir     = 1'b0;
		rm_point   = 1'b0;
		rm_spot    = 1'b0;
		clr_all    = 1'b0;
		case (gsha_pkg::opcode_t'(op_q))
			gsha_pkg::OP_ADD: begin
				case (pool_q)
					gsha_pkg::POOL_DIR: begin
						res_pool = gsha_pkg::POOL_DIR;
						if (dir_free) begin
							res_status = gsha_pkg::ST_OK;
							res_idx    = dir_free_idx;
							res_gen    = next_gen_q;
							res_cnt    = dir_cnt_q + 6'd1;
							add_dir    = 1'b1;
						end else begin
							res_status = gsha_pkg::ST_FULL;
							res_cnt    = dir_cnt_q;
						end
					end
					gsha_pkg::POOL_POINT: begin
						res_pool = gsha_pkg::POOL_POINT;
						if (point_free) begin
							res_status = gsha_pkg::ST_OK;
							res_idx    = point_free_idx;
							res_gen    = next_gen_q;
							res_cnt    = point_cnt_q + 6'd1;
							add_point  = 1'b1;
						end else begin
							res_status = gsha_pkg::ST_FULL;
							res_cnt    = point_cnt_q;
						end
					end
					gsha_pkg::POOL_SPOT: begin
						res_pool = gsha_pkg::POOL_SPOT;
						if (spot_free) begin
							res_status = gsha_pkg::ST_OK;
							res_idx    = spot_free_idx;
							res_gen    = next_gen_q;
							res_cnt    = spot_cnt_q + 6'd1;
							add_spot   = 1'b1;
						end else begin
							res_status = gsha_pkg::ST_FULL;
							res_cnt    = spot_cnt_q;
						end
					end
					default: begin
						res_status = gsha_pkg::ST_BAD;
					end
				endcase
			end
			gsha_pkg::OP_REMOVE: begin
				// first matching pool wins, in pool order
				if (gen_nz) begin
					if (dir_hit) begin
						res_status = gsha_pkg::ST_OK;
						res_idx    = idx_q;
						res_pool   = gsha_pkg::POOL_DIR;
						res_cnt    = dir_cnt_q - 6'd1;
						rm_dir     = 1'b1;
					end else if (point_hit) begin
						res_status = gsha_pkg::ST_OK;
						res_idx    = idx_q;
						res_pool   = gsha_pkg::POOL_POINT;
						res_cnt    = point_cnt_q - 6'd1;
						rm_point   = 1'b1;
					end else if (spot_hit) begin
						res_status = gsha_pkg::ST_OK;
						res_idx    = idx_q;
						res_pool   = gsha_pkg::POOL_SPOT;
						res_cnt    = spot_cnt_q - 6'd1;
						rm_spot    = 1'b1;
					end
				end
			end
			gsha_pkg::OP_CHECK: begin
				if (gen_nz) begin
					case (pool_q)
						gsha_pkg::POOL_DIR: begin
							if (dir_hit) begin
								res_status = gsha_pkg::ST_OK;
								res_idx    = idx_q;
								res_pool   = gsha_pkg::POOL_DIR;
								res_cnt    = dir_cnt_q;
							end
						end
						gsha_pkg::POOL_POINT: begin
							if (point_hit) begin
								res_status = gsha_pkg::ST_OK;
								res_idx    = idx_q;
								res_pool   = gsha_pkg::POOL_POINT;
								res_cnt    = point_cnt_q;
							end
						end
						gsha_pkg::POOL_SPOT: begin
							if (spot_hit) begin
								res_status = gsha_pkg::ST_OK;
								res_idx    = idx_q;
								res_pool   = gsha_pkg::POOL_SPOT;
								res_cnt    = spot_cnt_q;
							end
						end
						default: begin
							res_status = gsha_pkg::ST_BAD;
						end
					endcase
				end
			end
			gsha_pkg::OP_CLEAR: begin
				res_status = gsha_pkg::ST_OK;
				clr_all    = 1'b1;
			end
			default: begin
				res_status = gsha_pkg::ST_BAD;
			end
		endcase
	end

	logic any_add;
	logic [GEN_W-1:0] gen_inc;

	assign any_add = add_dir | add_point | add_spot;
	// skip generation zero on wrap
	assign gen_inc = (next_gen_q == '1) ? GEN_W'(1) : next_gen_q + GEN_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_act_q   <= '0;
			point_act_q <= '0;
			spot_act_q  <= '0;
			dir_cnt_q   <= '0;
			point_cnt_q <= '0;
			spot_cnt_q  <= '0;
			next_gen_q  <= GEN_W'(1);
		end else if (cmd.execute) begin
			if (clr_all) begin
				dir_act_q   <= '0;
				point_act_q <= '0;
				spot_act_q  <= '0;
				dir_cnt_q   <= '0;
				point_cnt_q <= '0;
				spot_cnt_q  <= '0;
			end
			if (add_dir) begin
				dir_act_q[dir_free_idx[DIR_AW-1:0]] <= 1'b1;
				dir_cnt_q <= res_cnt;
			end
			if (add_point) begin
				point_act_q[point_free_idx[POINT_AW-1:0]] <= 1'b1;
				point_cnt_q <= res_cnt;
			end
			if (add_spot) begin
				spot_act_q[spot_free_idx[SPOT_AW-1:0]] <= 1'b1;
				spot_cnt_q <= res_cnt;
			end
			if (rm_dir) begin
				dir_act_q[idx_q[DIR_AW-1:0]] <= 1'b0;
				dir_cnt_q <= res_cnt;
			end
			if (rm_point) begin
				point_act_q[idx_q[POINT_AW-1:0]] <= 1'b0;
				point_cnt_q <= res_cnt;
			end
			if (rm_spot) begin
				spot_act_q[idx_q[SPOT_AW-1:0]] <= 1'b0;
				spot_cnt_q <= res_cnt;
			end
			if (any_add) begin
				next_gen_q <= gen_inc;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.execute) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status_q     <= res_status;
			out_index_q  <= res_idx;
			out_gen_q    <= res_gen;
			out_pool_q   <= res_pool;
			pool_count_q <= res_cnt;
		end
	end

	assign stat.out_blocked = out_valid_q && !out_ready;

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign out_index      = out_index_q;
	assign out_generation = out_gen_q;
	assign out_pool       = out_pool_q;
	assign pool_count     = pool_count_q;

	// generation stores, read at the handle index when the word is captured
	gsha_ram #(.WIDTH(GEN_W), .DEPTH(DIR_SLOTS)) u_dir_ram (
		.clk     (clk),
		.wr_en   (cmd.execute && add_dir),
		.wr_addr (dir_free_idx[DIR_AW-1:0]),
		.wr_data (next_gen_q),
		.rd_en   (cmd.capture),
		.rd_addr (handle_index[DIR_AW-1:0]),
		.rd_data (dir_rdata)
	);

	gsha_ram #(.WIDTH(GEN_W), .DEPTH(POINT_SLOTS)) u_point_ram (
		.clk     (clk),
		.wr_en   (cmd.execute && add_point),
		.wr_addr (point_free_idx[POINT_AW-1:0]),
		.wr_data (next_gen_q),
		.rd_en   (cmd.capture),
		.rd_addr (handle_index[POINT_AW-1:0]),
		.rd_data (point_rdata)
	);

	gsha_ram #(.WIDTH(GEN_W), .DEPTH(SPOT_SLOTS)) u_spot_ram (
		.clk     (clk),
		.wr_en   (cmd.execute && add_spot),
		.wr_addr (spot_free_idx[SPOT_AW-1:0]),
		.wr_data (next_gen_q),
		.rd_en   (cmd.capture),
		.rd_addr (handle_index[SPOT_AW-1:0]),
		.rd_data (spot_rdata)
	);

endmodule

// ===== sim/gsha_alloc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsha_alloc_checker
// Watches both channels of the slot handle allocator. Keeps its own copy of
// the slot pools and the generation counter, predicts the result word of every
// accepted command and compares it, field by field, with the returned word.
// ----------------------------------------------------------------------------
module gsha_alloc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [gsha_pkg::OP_W-1:0]     opcode,
	input  logic [gsha_pkg::POOL_W-1:0]   pool,
	input  logic [gsha_pkg::IDX_W-1:0]    handle_index,
	input  logic [gsha_pkg::GEN_W-1:0]    handle_generation,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [gsha_pkg::ST_W-1:0]     status,
	input  logic [gsha_pkg::IDX_W-1:0]    out_index,
	input  logic [gsha_pkg::GEN_W-1:0]    out_generation,
	input  logic [gsha_pkg::POOL_W-1:0]   out_pool,
	input  logic [gsha_pkg::CNT_W-1:0]    pool_count,
	output int unsigned                   fault_count,
	output int unsigned                   pending
);

	localparam int unsigned POOL_W = gsha_pkg::POOL_W;
	localparam int unsigned IDX_W  = gsha_pkg::IDX_W;
	localparam int unsigned GEN_W  = gsha_pkg::GEN_W;
	localparam int unsigned CNT_W  = gsha_pkg::CNT_W;

	typedef struct packed {
		gsha_pkg::status_t  st;
		logic [IDX_W-1:0]   idx;
		logic [GEN_W-1:0]   gen;
		logic [POOL_W-1:0]  pl;
		logic [CNT_W-1:0]   cnt;
	} alloc_result_t;

	alloc_result_t      awaited_q[$];
	alloc_result_t      want;
	alloc_result_t      fresh;
	logic               slot_busy [3][32];
	logic [GEN_W-1:0]   slot_stamp [3][32];
	logic [CNT_W-1:0]   live_count [3];
	logic [GEN_W-1:0]   stamp_next;

	function automatic int unsigned pool_depth(input logic [POOL_W-1:0] pl);
		case (pl)
			gsha_pkg::POOL_DIR:   return gsha_pkg::DIR_SLOTS_DEF;
			gsha_pkg::POOL_POINT: return gsha_pkg::POINT_SLOTS_DEF;
			default:              return gsha_pkg::SPOT_SLOTS_DEF;
		endcase
	endfunction

	function automatic bit slot_hit(input logic [POOL_W-1:0] pl,
			input logic [IDX_W-1:0] idx, input logic [GEN_W-1:0] gen);
		if (idx >= pool_depth(pl))
			return 1'b0;
		return slot_busy[pl][idx] && slot_stamp[pl][idx] == gen;
	endfunction

	// Apply one command to the pool copy and return the word it must produce.
	function automatic alloc_result_t allocate_step(input gsha_pkg::opcode_t op,
			input logic [POOL_W-1:0] pl, input logic [IDX_W-1:0] idx,
			input logic [GEN_W-1:0] gen);
		alloc_result_t r;
		int            i;
		int            p;
		bit            found;
		r = '0;
		r.st = gsha_pkg::ST_BAD;
		found = 1'b0;
		case (op)
			gsha_pkg::OP_ADD: begin
				if (pl <= gsha_pkg::POOL_SPOT) begin
					r.pl = pl;
					if (live_count[pl] < pool_depth(pl)) begin
						for (i = 0; i < int'(pool_depth(pl)) && !found; i++) begin
							if (!slot_busy[pl][i]) begin
								found = 1'b1;
								slot_busy[pl][i] = 1'b1;
								slot_stamp[pl][i] = stamp_next;
								r.idx = IDX_W'(i);
								r.gen = stamp_next;
							end
						end
					end
					if (found) begin
						// zero stays reserved for the invalid handle
						stamp_next = stamp_next + 1'b1;
						if (stamp_next == '0)
							stamp_next = GEN_W'(1);
						live_count[pl] = live_count[pl] + 1'b1;
						r.st = gsha_pkg::ST_OK;
					end else begin
						r.st = gsha_pkg::ST_FULL;
					end
					r.cnt = live_count[pl];
				end
			end
			gsha_pkg::OP_REMOVE: begin
				if (gen != '0) begin
					for (p = 0; p < 3 && !found; p++) begin
						if (slot_hit(POOL_W'(p), idx, gen)) begin
							found = 1'b1;
							slot_busy[p][idx] = 1'b0;
							live_count[p] = live_count[p] - 1'b1;
							r.st = gsha_pkg::ST_OK;
							r.idx = idx;
							r.pl = POOL_W'(p);
							r.cnt = live_count[p];
						end
					end
				end
			end
			gsha_pkg::OP_CHECK: begin
				if (pl <= gsha_pkg::POOL_SPOT && gen != '0 && slot_hit(pl, idx, gen)) begin
					r.st = gsha_pkg::ST_OK;
					r.idx = idx;
					r.pl = pl;
					r.cnt = live_count[pl];
				end
			end
			default: begin
				for (p = 0; p < 3; p++) begin
					for (i = 0; i < 32; i++)
						slot_busy[p][i] = 1'b0;
					live_count[p] = '0;
				end
				r.st = gsha_pkg::ST_OK;
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want_v,
				got_v);
			fault_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < 3; p++) begin
				for (int i = 0; i < 32; i++) begin
					slot_busy[p][i] = 1'b0;
					slot_stamp[p][i] = '0;
				end
				live_count[p] = '0;
			end
			stamp_next = GEN_W'(1);
			awaited_q.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_q.size() == 0) begin
					$display("%0t ns: result word with none expected, %s %0h %0h %0h",
						$time, "actual status index gen", status, out_index,
						out_generation);
					fault_count++;
				end else begin
					want = awaited_q.pop_front();
					check_field("status", 32'(want.st), 32'(status));
					check_field("out_index", 32'(want.idx), 32'(out_index));
					check_field("out_generation", want.gen, out_generation);
					check_field("out_pool", 32'(want.pl), 32'(out_pool));
					check_field("pool_count", 32'(want.cnt), 32'(pool_count));
				end
			end
			if (in_valid && in_ready) begin
				fresh = allocate_step(gsha_pkg::opcode_t'(opcode), pool, handle_index,
					handle_generation);
				awaited_q = {awaited_q, fresh};
			end
			pending = awaited_q.size();
		end
	end

endmodule

// ===== sim/tb_generational_slot_handle_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_generational_slot_handle_allocator
// Drives add, remove, check and clear words into the allocator: a directed
// opening, then fill bursts and random traffic built from handles the block
// has granted, under several idle and stall patterns. Checking is done by
// the checker module beside the block.
// ----------------------------------------------------------------------------
module tb_generational_slot_handle_allocator;

	localparam int unsigned OP_W   = gsha_pkg::OP_W;
	localparam int unsigned POOL_W = gsha_pkg::POOL_W;
	localparam int unsigned IDX_W  = gsha_pkg::IDX_W;
	localparam int unsigned GEN_W  = gsha_pkg::GEN_W;
	localparam int unsigned ST_W   = gsha_pkg::ST_W;
	localparam int unsigned CNT_W  = gsha_pkg::CNT_W;

	localparam logic [POOL_W-1:0] POOL_NONE = 2'd3;

	typedef struct packed {
		logic [POOL_W-1:0] pl;
		logic [IDX_W-1:0]  idx;
		logic [GEN_W-1:0]  gen;
	} granted_handle_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [OP_W-1:0]      opcode = '0;
	logic [POOL_W-1:0]    pool = '0;
	logic [IDX_W-1:0]     handle_index = '0;
	logic [GEN_W-1:0]     handle_generation = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [ST_W-1:0]      status;
	logic [IDX_W-1:0]     out_index;
	logic [GEN_W-1:0]     out_generation;
	logic [POOL_W-1:0]    out_pool;
	logic [CNT_W-1:0]     pool_count;
	int unsigned          fault_count;
	int unsigned          pending;

	int unsigned          idle_pct = 0;
	int unsigned          stall_pct = 0;
	logic                 hold_req = 1'b0;
	logic                 hold_done = 1'b0;
	int                   hold_left = 0;
	granted_handle_t      granted_q[$];

	generational_slot_handle_allocator dut (.*);

	gsha_alloc_checker u_alloc_check (.*);

	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off to back up the block.
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= 80;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Collect handles granted by the block; random traffic reuses them.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready && status == gsha_pkg::ST_OK
				&& out_generation != '0) begin
			granted_q = {granted_q,
				granted_handle_t'{out_pool, out_index, out_generation}};
			if (granted_q.size() > 96)
				void'(granted_q.pop_front());
		end
	end

	task automatic send_word(input gsha_pkg::opcode_t op, input logic [POOL_W-1:0] pl,
			input logic [IDX_W-1:0] idx, input logic [GEN_W-1:0] gen);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		pool <= pl;
		handle_index <= idx;
		handle_generation <= gen;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Drop valid and hold until every result word has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_random_command();
		int unsigned     r;
		granted_handle_t h;
		logic [GEN_W-1:0] gen;
		r = $urandom_range(999);
		h = '0;
		if (granted_q.size() != 0)
			h = granted_q[$urandom_range(granted_q.size() - 1)];
		gen = h.gen;
		// flip one bit now and then to get stale or forged handles
		if ($urandom_range(7) == 0)
			gen = gen ^ (32'd1 << $urandom_range(31));
		if (r < 5) begin
			send_word(gsha_pkg::OP_CLEAR, POOL_W'($urandom_range(3)),
				IDX_W'($urandom_range(31)), $urandom());
		end else if (r < 420) begin
			send_word(gsha_pkg::OP_ADD, ($urandom_range(19) == 0) ? POOL_NONE :
				POOL_W'($urandom_range(2)), IDX_W'($urandom_range(31)), $urandom());
		end else if (r < 650 && granted_q.size() != 0) begin
			send_word(gsha_pkg::OP_REMOVE, POOL_W'($urandom_range(3)), h.idx, gen);
		end else if (r < 850 && granted_q.size() != 0) begin
			send_word(gsha_pkg::OP_CHECK,
				($urandom_range(5) == 0) ? POOL_W'($urandom_range(3)) : h.pl, h.idx, gen);
		end else begin
			send_word(gsha_pkg::opcode_t'($urandom_range(2)), POOL_W'($urandom_range(3)),
				IDX_W'($urandom_range(31)), ($urandom_range(7) == 0) ? '0 : $urandom());
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Generations count up from one after reset.
		send_word(gsha_pkg::OP_ADD, gsha_pkg::POOL_DIR, 5'd0, 32'd0);
		send_word(gsha_pkg::OP_ADD, gsha_pkg::POOL_POINT, 5'd31, 32'hFFFF_FFFF);
		send_word(gsha_pkg::OP_ADD, gsha_pkg::POOL_SPOT, 5'd0, 32'd0);
		send_word(gsha_pkg::OP_ADD, gsha_pkg::POOL_DIR, 5'd0, 32'd0);
		send_word(gsha_pkg::OP_ADD, gsha_pkg::POOL_DIR, 5'd0, 32'd0);
		send_word(gsha_pkg::OP_ADD, gsha_pkg::POOL_DIR, 5'd0, 32'd0);
		send_word(gsha_pkg::OP_ADD, gsha_pkg::POOL_DIR, 5'd0, 32'd0);
		send_word(gsha_pkg::OP_ADD, POOL_NONE, 5'd0, 32'd1);
		send_word(gsha_pkg::OP_REMOVE, gsha_pkg::POOL_DIR, 5'd2, 32'd5);
		send_word(gsha_pkg::OP_CHECK, gsha_pkg::POOL_POINT, 5'd0, 32'd2);
		send_word(gsha_pkg::OP_CHECK, gsha_pkg::POOL_DIR, 5'd10, 32'd2);
		send_word(gsha_pkg::OP_REMOVE, gsha_pkg::POOL_DIR, 5'd0, 32'd2);
		send_word(gsha_pkg::OP_REMOVE, gsha_pkg::POOL_DIR, 5'd0, 32'd0);
		send_word(gsha_pkg::OP_CHECK, gsha_pkg::POOL_DIR, 5'd0, 32'd0);
		send_word(gsha_pkg::OP_CHECK, POOL_NONE, 5'd0, 32'd1);
		send_word(gsha_pkg::OP_ADD, gsha_pkg::POOL_DIR, 5'd0, 32'd0);
		send_word(gsha_pkg::OP_REMOVE, gsha_pkg::POOL_DIR, 5'd31, 32'hFFFF_FFFF);
		send_word(gsha_pkg::OP_CHECK, gsha_pkg::POOL_SPOT, 5'd31, 32'hFFFF_FFFF);
		send_word(gsha_pkg::OP_REMOVE, POOL_NONE, 5'd0, 32'd3);
		send_word(gsha_pkg::OP_CLEAR, POOL_NONE, 5'd31, 32'hFFFF_FFFF);
		send_word(gsha_pkg::OP_CHECK, gsha_pkg::POOL_DIR, 5'd0, 32'd1);
		send_word(gsha_pkg::OP_ADD, gsha_pkg::POOL_SPOT, 5'd0, 32'd0);
		send_word(gsha_pkg::OP_REMOVE, gsha_pkg::POOL_SPOT, 5'd21, 32'h5555_AAAA);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct <= 0;  end
				1: begin idle_pct = 56; stall_pct <= 0;  end
				2: begin idle_pct = 0;  stall_pct <= 56; end
				default: begin idle_pct = 7; stall_pct <= 7; end
			endcase
			// fill one pool to the brim first
			for (int n = 0; n < 34; n++)
				send_word(gsha_pkg::OP_ADD,
					phase[0] ? gsha_pkg::POOL_SPOT : gsha_pkg::POOL_POINT,
					IDX_W'($urandom_range(31)), $urandom());
			for (int n = 0; n < 236; n++) begin
				if (phase == 0 && n == 100)
					hold_req <= 1'b1;
				send_random_command();
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
